FILE: rtl/nsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and constants of the netstring deframer.
// ----------------------------------------------------------------------------
package nsd_pkg;

	localparam int unsigned DEF_MAX_FRAME_BYTES = 128;

	localparam logic [7:0] RST_MAX_PAYLOAD_LEN = 8'd124;
	localparam logic [7:0] RST_TERMINATOR_CHAR = 8'd59;
	localparam logic [7:0] COLON_CHAR          = 8'h3a;
	localparam logic [7:0] DIGIT_ZERO          = 8'h30;
	localparam logic [7:0] DIGIT_NINE          = 8'h39;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// Register index, taken from the word address bit of paddr.
	typedef enum logic {
		REG_MAX_PAYLOAD_LEN = 1'b0,
		REG_TERMINATOR_CHAR = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_TERM    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_GOOD  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_HEADER   = 2'd1,
		ERR_TOO_LONG = 2'd2,
		ERR_TERM     = 2'd3
	} err_t;

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
	endfunction

endpackage

FILE: rtl/nsd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_in_if
// Byte channel into the deframer: one stream byte per beat.
// ----------------------------------------------------------------------------
interface nsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

FILE: rtl/nsd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_out_if
// Result channel out of the deframer: one payload byte, end or error per beat.
// ----------------------------------------------------------------------------
interface nsd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       out_last;
	logic [1:0] err_code;
	logic [7:0] frame_len;

	modport source (output valid, output out_kind, output out_byte, output out_last,
		output err_code, output frame_len, input ready);
	modport sink (input valid, input out_kind, input out_byte, input out_last,
		input err_code, input frame_len, output ready);
endinterface

FILE: rtl/netstring_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// netstring_deframer
// Splits a byte stream into <length>':'<payload><terminator> frames.
// ----------------------------------------------------------------------------
// A byte accepted on din passes the input register and then the result register to dout.
// Throughput: one byte per cycle unless dout stalls; the input register and the
// result register let a new byte enter while a finished result still waits on dout.
// Reset (arst_n low, asynchronous): the parser returns to header hunt, both
// channels go empty and the registers take their defaults (124 and ';').
module netstring_deframer #(
	parameter int unsigned MAX_FRAME_BYTES = nsd_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	nsd_in_if.sink                         din,
	nsd_out_if.source                      dout,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nsd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [nsd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [nsd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	localparam logic [7:0] FRAME_LIMIT = 8'(MAX_FRAME_BYTES);

	logic [7:0] max_len_q;
	logic [7:0] term_q;
	logic       cfg_wr;
	nsd_pkg::reg_idx_t cfg_idx;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;

	nsd_pkg::phase_t phase_q, phase_d;
	logic [7:0] len_q, len_d;
	logic [7:0] left_q, left_d;
	logic       seen_q, seen_d;

	logic [7:0]  limit;
	logic        is_digit;
	logic [11:0] next_len;
	logic [7:0]  left_dec;

	logic            emit;
	nsd_pkg::kind_t  kind_d;
	nsd_pkg::err_t   err_d;
	logic [7:0]      obyte_d;
	logic            last_d;
	logic [7:0]      flen_d;

	logic            out_valid_q;
	nsd_pkg::kind_t  kind_q;
	nsd_pkg::err_t   err_q;
	logic [7:0]      obyte_q;
	logic            last_q;
	logic [7:0]      flen_q;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_idx = nsd_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= nsd_pkg::RST_MAX_PAYLOAD_LEN;
			term_q    <= nsd_pkg::RST_TERMINATOR_CHAR;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				nsd_pkg::REG_MAX_PAYLOAD_LEN: max_len_q <= pwdata[7:0];
				nsd_pkg::REG_TERMINATOR_CHAR: term_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			nsd_pkg::REG_MAX_PAYLOAD_LEN: prdata = {24'd0, max_len_q};
			nsd_pkg::REG_TERMINATOR_CHAR: prdata = {24'd0, term_q};
			default:                      prdata = '0;
		endcase
	end

	// Input register. The parse step fires when the result register is free or being read.
	assign fire      = valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1 <= din.in_byte;
		end
	end

	// Length arithmetic: len * 10 as two shifts, plus the digit's low nibble.
	assign limit    = (max_len_q > FRAME_LIMIT) ? FRAME_LIMIT : max_len_q;
	assign is_digit = (byte_s1 >= nsd_pkg::DIGIT_ZERO) && (byte_s1 <= nsd_pkg::DIGIT_NINE);
	assign next_len = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} + {8'd0, byte_s1[3:0]};
	assign left_dec = (left_q != 8'd0) ? (left_q - 8'd1) : left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nsd_pkg::PH_HUNT;
			len_q   <= 8'd0;
			left_q  <= 8'd0;
			seen_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			left_q  <= left_d;
			seen_q  <= seen_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		left_d  = left_q;
		seen_d  = seen_q;
		emit    = 1'b0;
		kind_d  = nsd_pkg::KIND_BYTE;
		err_d   = nsd_pkg::ERR_NONE;
		obyte_d = 8'd0;
		last_d  = 1'b0;
		flen_d  = 8'd0;
		unique case (phase_q)
			nsd_pkg::PH_PAYLOAD: begin
				emit    = 1'b1;
				obyte_d = byte_s1;
				left_d  = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = nsd_pkg::PH_TERM;
				end
			end
			nsd_pkg::PH_TERM: begin
				emit    = 1'b1;
				last_d  = 1'b1;
				phase_d = nsd_pkg::PH_HUNT;
				len_d   = 8'd0;
				left_d  = 8'd0;
				seen_d  = 1'b0;
				if (byte_s1 == term_q) begin
					kind_d = nsd_pkg::KIND_GOOD;
					flen_d = len_q;
				end else begin
					kind_d = nsd_pkg::KIND_ERROR;
					err_d  = nsd_pkg::ERR_TERM;
				end
			end
			default: begin
				// Header hunt; the unused phase code is parsed the same way.
				priority if (!seen_q && nsd_pkg::is_space(byte_s1)) begin
					phase_d = phase_q;
				end else if (is_digit && (next_len <= {4'd0, limit})) begin
					len_d  = next_len[7:0];
					seen_d = 1'b1;
				end else if (byte_s1 == nsd_pkg::COLON_CHAR) begin
					left_d  = len_q;
					seen_d  = 1'b0;
					phase_d = (len_q == 8'd0) ? nsd_pkg::PH_TERM : nsd_pkg::PH_PAYLOAD;
				end else begin
					emit    = 1'b1;
					last_d  = 1'b1;
					kind_d  = nsd_pkg::KIND_ERROR;
					err_d   = is_digit ? nsd_pkg::ERR_TOO_LONG : nsd_pkg::ERR_HEADER;
					phase_d = nsd_pkg::PH_HUNT;
					len_d   = 8'd0;
					left_d  = 8'd0;
					seen_d  = 1'b0;
				end
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= emit;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q  <= kind_d;
			err_q   <= err_d;
			obyte_q <= obyte_d;
			last_q  <= last_d;
			flen_q  <= flen_d;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.out_kind  = kind_q;
	assign dout.out_byte  = obyte_q;
	assign dout.out_last  = last_q;
	assign dout.err_code  = err_q;
	assign dout.frame_len = flen_q;

endmodule

FILE: rtl/nsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_checker
// Port-level checks on the result channel of the netstring deframer.
// ----------------------------------------------------------------------------
module nsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic [1:0] err_code,
	input logic [7:0] frame_len
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_byte) &&
			$stable(out_last) && $stable(err_code) && $stable(frame_len))
		else $error("result beat changed while stalled");

	// Only end and error beats close a frame, and a payload beat carries no status.
	a_last_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_kind != nsd_pkg::KIND_BYTE)) &&
			(out_kind != nsd_pkg::KIND_BYTE || (err_code == nsd_pkg::ERR_NONE &&
			frame_len == 8'd0)))
		else $error("last flag or status does not match beat kind");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == nsd_pkg::KIND_ERROR |->
			err_code != nsd_pkg::ERR_NONE && frame_len == 8'd0 && out_byte == 8'd0)
		else $error("error beat with bad fields");

endmodule

bind netstring_deframer nsd_checker u_nsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_kind  (dout.out_kind),
	.out_byte  (dout.out_byte),
	.out_last  (dout.out_last),
	.err_code  (dout.err_code),
	.frame_len (dout.frame_len)
);

FILE: sim/tb_netstring_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_netstring_deframer
// Self-checking bench for the netstring deframer. A byte driver and a result
// monitor run as clocked processes with random stalls on both channels. Every
// accepted byte goes through a behavioral deframer kept in the bench, and every
// result beat is compared field by field with the oldest prediction. Register
// settings change between phases over the APB port, including the extremes.
// ----------------------------------------------------------------------------
module tb_netstring_deframer;

	localparam int unsigned FRAME_CAP = nsd_pkg::DEF_MAX_FRAME_BYTES;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned PHASE_BYTES = 230;
	localparam int unsigned PHASE_COUNT = 8;

	typedef struct packed {
		nsd_pkg::kind_t kind;
		logic [7:0]     data;
		logic           last;
		nsd_pkg::err_t  err;
		logic [7:0]     len;
	} frame_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [nsd_pkg::APB_ADDR_W-1:0] paddr;
	logic [nsd_pkg::APB_DATA_W-1:0] pwdata;
	logic [nsd_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	nsd_in_if in_ch ();
	nsd_out_if out_ch ();

	netstring_deframer #(
		.MAX_FRAME_BYTES(FRAME_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(in_ch),
		.dout(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Bench copy of the deframer state and its registers.
	logic [7:0] cfg_max_len;
	logic [7:0] cfg_term;
	nsd_pkg::phase_t st_phase;
	logic [7:0] st_len;
	logic [7:0] st_left;
	logic st_digit_seen;

	logic [7:0] tx_bytes[$];
	frame_result_t want_results[$];
	int unsigned err_count;
	int unsigned send_gap;
	int unsigned recv_stall;
	int unsigned quiet_cycles;
	bit idling_on;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic void restart_hunt();
		st_phase = nsd_pkg::PH_HUNT;
		st_len = 8'd0;
		st_left = 8'd0;
		st_digit_seen = 1'b0;
	endfunction

	// Returns 1 when the byte produces a result beat.
	function automatic bit deframe_byte(input logic [7:0] c, output frame_result_t r);
		int unsigned lim;
		int unsigned nxt;
		r.kind = nsd_pkg::KIND_BYTE;
		r.data = 8'd0;
		r.last = 1'b0;
		r.err = nsd_pkg::ERR_NONE;
		r.len = 8'd0;
		lim = (32'(cfg_max_len) > FRAME_CAP) ? FRAME_CAP : 32'(cfg_max_len);
		if (st_phase == nsd_pkg::PH_PAYLOAD) begin
			r.data = c;
			if (st_left > 8'd0)
				st_left = st_left - 8'd1;
			if (st_left == 8'd0)
				st_phase = nsd_pkg::PH_TERM;
			return 1'b1;
		end
		if (st_phase == nsd_pkg::PH_TERM) begin
			r.last = 1'b1;
			if (c == cfg_term) begin
				r.kind = nsd_pkg::KIND_GOOD;
				r.len = st_len;
			end else begin
				r.kind = nsd_pkg::KIND_ERROR;
				r.err = nsd_pkg::ERR_TERM;
			end
			restart_hunt();
			return 1'b1;
		end
		// Header hunt; whitespace is only skipped before the first digit.
		if (!st_digit_seen && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)))
			return 1'b0;
		if (c >= nsd_pkg::DIGIT_ZERO && c <= nsd_pkg::DIGIT_NINE) begin
			nxt = 32'(st_len) * 10 + 32'(c - nsd_pkg::DIGIT_ZERO);
			if (nxt > lim) begin
				r.kind = nsd_pkg::KIND_ERROR;
				r.last = 1'b1;
				r.err = nsd_pkg::ERR_TOO_LONG;
				restart_hunt();
				return 1'b1;
			end
			st_len = nxt[7:0];
			st_digit_seen = 1'b1;
			return 1'b0;
		end
		if (c == nsd_pkg::COLON_CHAR) begin
			st_left = st_len;
			st_digit_seen = 1'b0;
			st_phase = (st_len == 8'd0) ? nsd_pkg::PH_TERM : nsd_pkg::PH_PAYLOAD;
			return 1'b0;
		end
		r.kind = nsd_pkg::KIND_ERROR;
		r.last = 1'b1;
		r.err = nsd_pkg::ERR_HEADER;
		restart_hunt();
		return 1'b1;
	endfunction

	task automatic predict_byte(input logic [7:0] c);
		frame_result_t r;
		if (deframe_byte(c, r))
			want_results.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	task automatic check_result();
		frame_result_t w;
		if (want_results.size() == 0) begin
			$display("%0t: result beat expected none actual kind %0d", $time,
				out_ch.out_kind);
			err_count++;
		end else begin
			w = want_results.pop_front();
			check_field("out_kind", 8'(w.kind), 8'(out_ch.out_kind));
			check_field("out_byte", w.data, out_ch.out_byte);
			check_field("out_last", 8'(w.last), 8'(out_ch.out_last));
			check_field("err_code", 8'(w.err), 8'(out_ch.err_code));
			check_field("frame_len", w.len, out_ch.frame_len);
		end
	endtask

	// Byte driver: a beat on offer is held until taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predict_byte(in_ch.in_byte);
			if (in_ch.valid && !in_ch.ready) begin
				// Keep the pending beat steady.
			end else if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
			end else if (tx_bytes.size() > 0 && idling_on && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 4);
				in_ch.valid <= 1'b0;
			end else if (tx_bytes.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.in_byte <= tx_bytes.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_result();
			if (recv_stall > 0) begin
				recv_stall--;
				out_ch.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				recv_stall = $urandom_range(0, 4);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("netstring_deframer: mismatch");
			$finish;
		end
	end

	task automatic reg_write(input nsd_pkg::reg_idx_t idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == nsd_pkg::REG_MAX_PAYLOAD_LEN)
			cfg_max_len = value;
		else
			cfg_term = value;
	endtask

	task automatic queue_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
	endtask

	task automatic queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			tx_bytes.push_back(s[i]);
	endtask

	task automatic queue_number(input int unsigned n, input bit lead_zero);
		string s;
		s = $sformatf("%0d", n);
		if (lead_zero)
			s = {"0", s};
		queue_text(s);
	endtask

	task automatic queue_random_frame();
		int unsigned lim;
		int unsigned sel;
		int unsigned n;
		int unsigned i;
		logic [7:0] b;
		lim = (32'(cfg_max_len) > FRAME_CAP) ? FRAME_CAP : 32'(cfg_max_len);
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0)
			queue_byte(($urandom_range(0, 5) == 5) ? 8'h20 :
				8'(8'h09 + $urandom_range(0, 4)));
		if (sel < 70) begin
			// Frame with a good header, mostly short, now and then at the limit; one in ten ends badly.
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: n = $urandom_range(0, (lim < 8) ? lim : 8);
			6, 7, 8: n = $urandom_range(0, lim);
			default: n = lim;
			endcase
			queue_number(n, $urandom_range(0, 7) == 0);
			queue_byte(nsd_pkg::COLON_CHAR);
			for (i = 0; i < n; i++)
				queue_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) == 0) begin
				b = 8'($urandom_range(0, 255));
				if (b == cfg_term)
					b = b ^ 8'h01;
				queue_byte(b);
			end else begin
				queue_byte(cfg_term);
			end
		end else if (sel < 80) begin
			queue_number(lim + 1 + $urandom_range(0, 50), 1'b0);
		end else if (sel < 86) begin
			queue_byte(nsd_pkg::COLON_CHAR);
			queue_byte(cfg_term);
		end else if (sel < 93) begin
			// Digits followed by a random byte, usually a bad header char.
			queue_number($urandom_range(0, 9), 1'b0);
			queue_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 3))
				queue_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic drain();
		while (tx_bytes.size() > 0 || in_ch.valid || want_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned p;
		int unsigned mark;
		int unsigned pre_size;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'd0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_count = 0;
		send_gap = 0;
		recv_stall = 0;
		quiet_cycles = 0;
		idling_on = 1'b1;
		cfg_max_len = nsd_pkg::RST_MAX_PAYLOAD_LEN;
		cfg_term = nsd_pkg::RST_TERMINATOR_CHAR;
		restart_hunt();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames under the reset settings.
		queue_byte(8'h20);
		queue_byte(8'h09);
		queue_text("3:");
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_byte(8'h80);
		queue_byte(nsd_pkg::RST_TERMINATOR_CHAR);
		queue_text(":;");
		queue_text("1:xQ");
		queue_text("1 ");
		queue_text("+-A");
		queue_byte(8'h0a);
		queue_byte(8'h0b);
		queue_byte(8'h0c);
		queue_byte(8'h0d);
		queue_text("125");
		queue_text("2:");
		queue_byte(8'h7f);
		queue_byte(8'h01);
		queue_byte(nsd_pkg::RST_TERMINATOR_CHAR);
		drain();

		for (p = 0; p < PHASE_COUNT; p++) begin
			case (p)
			0: begin
				reg_write(nsd_pkg::REG_MAX_PAYLOAD_LEN, 8'd0);
				reg_write(nsd_pkg::REG_TERMINATOR_CHAR, 8'h00);
			end
			1: begin
				reg_write(nsd_pkg::REG_MAX_PAYLOAD_LEN, 8'd128);
				reg_write(nsd_pkg::REG_TERMINATOR_CHAR, 8'hff);
			end
			2: begin
				reg_write(nsd_pkg::REG_MAX_PAYLOAD_LEN, 8'd255);
				reg_write(nsd_pkg::REG_TERMINATOR_CHAR, nsd_pkg::RST_TERMINATOR_CHAR);
			end
			3: begin
				reg_write(nsd_pkg::REG_MAX_PAYLOAD_LEN, 8'd10);
				reg_write(nsd_pkg::REG_TERMINATOR_CHAR, nsd_pkg::COLON_CHAR);
			end
			4: begin
				reg_write(nsd_pkg::REG_MAX_PAYLOAD_LEN, 8'd1);
				reg_write(nsd_pkg::REG_TERMINATOR_CHAR, nsd_pkg::DIGIT_ZERO);
			end
			5: begin
				reg_write(nsd_pkg::REG_MAX_PAYLOAD_LEN, 8'd99);
				reg_write(nsd_pkg::REG_TERMINATOR_CHAR, 8'h20);
			end
			default: begin
				reg_write(nsd_pkg::REG_MAX_PAYLOAD_LEN, 8'($urandom_range(0, 128)));
				reg_write(nsd_pkg::REG_TERMINATOR_CHAR, 8'($urandom_range(0, 255)));
			end
			endcase
			// The closing phase runs at full rate on both sides.
			if (p == PHASE_COUNT - 1)
				idling_on = 1'b0;
			mark = 0;
			while (mark < PHASE_BYTES) begin
				pre_size = tx_bytes.size();
				queue_random_frame();
				mark = mark + (tx_bytes.size() - pre_size);
				while (tx_bytes.size() > 64)
					@(posedge clk);
			end
			drain();
		end

		if (err_count == 0 && want_results.size() == 0) begin
			$display("netstring_deframer: match");
		end else begin
			$display("netstring_deframer: mismatch");
		end
		$finish;
	end

endmodule
